### rtl/rpn_pkg.sv
// Shared constants, types and command/status codes for the RPN stack calculator.
// No dependencies; imported by the stack memory, divider and top level.
package rpn_pkg;

  localparam int DATA_W              = 32;
  localparam int FUNC_W              = 3;
  localparam int STATUS_W            = 3;
  localparam int DEPTH_OUT_W         = 5;
  localparam int DEFAULT_STACK_DEPTH = 16;

  typedef logic signed [DATA_W-1:0]   data_t;
  typedef logic        [DATA_W-1:0]   mag_t;
  typedef logic        [FUNC_W-1:0]   func_t;
  typedef logic        [STATUS_W-1:0] status_t;

  // Command codes
  localparam func_t FN_PUSH = 3'd0;
  localparam func_t FN_ADD  = 3'd1;
  localparam func_t FN_SUB  = 3'd2;
  localparam func_t FN_MUL  = 3'd3;
  localparam func_t FN_DIV  = 3'd4;
  localparam func_t FN_CLR  = 3'd5;
  localparam func_t FN_READ = 3'd6;

  // Status codes
  localparam status_t ST_OK    = 3'd0;
  localparam status_t ST_UNDER = 3'd1;
  localparam status_t ST_FULL  = 3'd2;
  localparam status_t ST_DIVZ  = 3'd3;
  localparam status_t ST_SAT   = 3'd4;

  // Saturation bounds
  localparam data_t SAT_MAX = 32'sh7FFF_FFFF;
  localparam data_t SAT_MIN = 32'sh8000_0000;

endpackage

### rtl/rpn_stack_mem.sv
// Stack storage: one write port and one read port, registered read data.
// Depends on rpn_pkg for the data type.
module rpn_stack_mem
  import rpn_pkg::*;
#(
  parameter int DEPTH  = DEFAULT_STACK_DEPTH,
  parameter int ADDR_W = $clog2(DEPTH)
) (
  input  logic              clk,
  input  logic              wr_en,
  input  logic [ADDR_W-1:0] wr_addr,
  input  data_t             wr_data,
  input  logic [ADDR_W-1:0] rd_addr,
  output data_t             rd_data
);

  data_t mem [DEPTH];

  // Write the addressed entry
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  // Register the read data
  always_ff @(posedge clk) begin
    rd_data <= mem[rd_addr];
  end

endmodule

### rtl/rpn_divider.sv
// Restoring divider on unsigned magnitudes, one quotient bit per cycle.
// Depends on rpn_pkg for the data width and magnitude type.
module rpn_divider
  import rpn_pkg::*;
(
  input  logic clk,
  input  logic rst,
  input  logic start,
  input  mag_t dividend,
  input  mag_t divisor,
  output logic done,
  output mag_t quotient
);

  localparam int STEP_W = $clog2(DATA_W);

  logic              busy;
  logic [STEP_W-1:0] step;
  mag_t              rem;
  mag_t              quo;
  mag_t              dvsr;
  logic [DATA_W:0]   shifted;
  logic [DATA_W:0]   diff;

  // Shift in the next dividend bit and trial-subtract the divisor
  always_comb begin
    shifted = {rem, quo[DATA_W-1]};
    diff    = shifted - {1'b0, dvsr};
  end

  // Control: run one step per cycle, pulse done after the last one
  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      step <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
        step <= '0;
      end else if (busy) begin
        step <= step + STEP_W'(1);
        if (step == STEP_W'(DATA_W - 1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  // Datapath: partial remainder and quotient shift register
  always_ff @(posedge clk) begin
    if (start) begin
      rem  <= '0;
      quo  <= dividend;
      dvsr <= divisor;
    end else if (busy) begin
      if (!diff[DATA_W]) begin
        rem <= diff[DATA_W-1:0];
        quo <= {quo[DATA_W-2:0], 1'b1};
      end else begin
        rem <= shifted[DATA_W-1:0];
        quo <= {quo[DATA_W-2:0], 1'b0};
      end
    end
  end

  assign quotient = quo;

endmodule

### rtl/rpn_stack_calculator.sv
// RPN stack calculator on signed 32-bit integers, stack held in a synchronous RAM.
// Push, add, subtract, read and invalid commands pass through the execute and done states;
// multiply and clear also pass through S_MUL or S_CLR, divide waits in S_DIV on the 32-step divider.
// One transaction in flight; the next input can be taken in the same cycle that the result becomes valid.
// Reset (synchronous, active high) empties the stack; RAM contents are not cleared.
// Uses rpn_pkg, rpn_stack_mem and rpn_divider.
module rpn_stack_calculator
  import rpn_pkg::*;
#(
  parameter int STACK_DEPTH = DEFAULT_STACK_DEPTH
) (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   in_valid,
  output logic                   in_ready,
  input  func_t                  func,
  input  data_t                  operand,
  output logic                   out_valid,
  input  logic                   out_ready,
  output data_t                  top_value,
  output logic [DEPTH_OUT_W-1:0] stack_depth,
  output status_t                status
);

  localparam int ADDR_W = $clog2(STACK_DEPTH);
  localparam int CNT_W  = $clog2(STACK_DEPTH + 1);

  localparam logic [2:0] S_IDLE = 3'd0;
  localparam logic [2:0] S_EXEC = 3'd1;
  localparam logic [2:0] S_MUL  = 3'd2;
  localparam logic [2:0] S_DIV  = 3'd3;
  localparam logic [2:0] S_CLR  = 3'd4;
  localparam logic [2:0] S_DONE = 3'd5;

  logic [2:0]       state;
  func_t            func_q;
  data_t            operand_q;
  logic [CNT_W-1:0] count;
  data_t            top;
  status_t          status_q;
  logic             div_neg;
  logic signed [2*DATA_W-1:0] prod;

  logic [CNT_W-1:0] cnt_m1;
  logic [CNT_W-1:0] cnt_m2;
  logic             full;
  logic             under;

  logic              wr_en;
  logic [ADDR_W-1:0] wr_addr;
  data_t             wr_data;
  data_t             left;
  data_t             right;

  logic signed [DATA_W:0] sum_ext;
  logic                   sum_ovf;
  data_t                  sum_res;
  logic                   mul_ovf;
  data_t                  mul_res;

  logic div_start;
  logic div_done;
  mag_t div_q;
  mag_t left_mag;
  mag_t right_mag;
  logic div_ovf;
  data_t div_res;

  logic [CNT_W+DEPTH_OUT_W-1:0] cnt_ext;

  // Stack pointers and occupancy checks
  assign cnt_m1 = count - CNT_W'(1);
  assign cnt_m2 = count - CNT_W'(2);
  assign full   = (count == CNT_W'(STACK_DEPTH));
  assign under  = (count < CNT_W'(2));
  assign right  = top;
  assign in_ready = (state == S_IDLE);

  rpn_stack_mem #(
    .DEPTH  (STACK_DEPTH),
    .ADDR_W (ADDR_W)
  ) u_mem (
    .clk     (clk),
    .wr_en   (wr_en),
    .wr_addr (wr_addr),
    .wr_data (wr_data),
    .rd_addr (cnt_m2[ADDR_W-1:0]),
    .rd_data (left)
  );

  // Add/subtract with saturation
  always_comb begin
    if (func_q == FN_SUB) begin
      sum_ext = {left[DATA_W-1], left} - {right[DATA_W-1], right};
    end else begin
      sum_ext = {left[DATA_W-1], left} + {right[DATA_W-1], right};
    end
    sum_ovf = (sum_ext[DATA_W] != sum_ext[DATA_W-1]);
    sum_res = sum_ovf ? (sum_ext[DATA_W] ? SAT_MIN : SAT_MAX) : sum_ext[DATA_W-1:0];
  end

  // Saturate the registered product
  always_comb begin
    mul_ovf = !((&prod[2*DATA_W-1:DATA_W-1]) || !(|prod[2*DATA_W-1:DATA_W-1]));
    mul_res = mul_ovf ? (prod[2*DATA_W-1] ? SAT_MIN : SAT_MAX) : prod[DATA_W-1:0];
  end

  // Divider operands as magnitudes; apply the sign to the quotient
  always_comb begin
    left_mag  = left[DATA_W-1]  ? (~left + DATA_W'(1))  : left;
    right_mag = right[DATA_W-1] ? (~right + DATA_W'(1)) : right;
    div_start = (state == S_EXEC) && (func_q == FN_DIV) && !under && (right != '0);
    div_ovf   = !div_neg && div_q[DATA_W-1];
    if (div_ovf) begin
      div_res = SAT_MAX;
    end else if (div_neg) begin
      div_res = ~div_q + DATA_W'(1);
    end else begin
      div_res = div_q;
    end
  end

  rpn_divider u_div (
    .clk      (clk),
    .rst      (rst),
    .start    (div_start),
    .dividend (left_mag),
    .divisor  (right_mag),
    .done     (div_done),
    .quotient (div_q)
  );

  // Write port: push, operation results and clearing zeros
  always_comb begin
    wr_en   = 1'b0;
    wr_addr = cnt_m2[ADDR_W-1:0];
    wr_data = sum_res;
    case (state)
      S_EXEC: begin
        if (func_q == FN_PUSH && !full) begin
          wr_en   = 1'b1;
          wr_addr = count[ADDR_W-1:0];
          wr_data = operand_q;
        end else if ((func_q == FN_ADD || func_q == FN_SUB) && !under) begin
          wr_en   = 1'b1;
        end else if (func_q == FN_CLR && !under) begin
          wr_en   = 1'b1;
          wr_data = '0;
        end
      end
      S_MUL: begin
        wr_en   = 1'b1;
        wr_data = mul_res;
      end
      S_DIV: begin
        wr_en   = div_done;
        wr_data = div_res;
      end
      S_CLR: begin
        wr_en   = 1'b1;
        wr_addr = cnt_m1[ADDR_W-1:0];
        wr_data = '0;
      end
      default: begin
        wr_en = 1'b0;
      end
    endcase
  end

  // Sequencer: accept, execute, wait on multi-cycle units, deliver result
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      count     <= '0;
      out_valid <= 1'b0;
    end else begin
      if (out_valid && out_ready && (state != S_DONE)) begin
        out_valid <= 1'b0;
      end
      case (state)
        S_IDLE: begin
          if (in_valid) begin
            state <= S_EXEC;
          end
        end
        S_EXEC: begin
          state <= S_DONE;
          case (func_q)
            FN_PUSH: begin
              if (!full) begin
                count <= count + CNT_W'(1);
              end
            end
            FN_ADD, FN_SUB: begin
              if (!under) begin
                count <= cnt_m1;
              end
            end
            FN_MUL: begin
              if (!under) begin
                state <= S_MUL;
              end
            end
            FN_DIV: begin
              if (div_start) begin
                state <= S_DIV;
              end
            end
            FN_CLR: begin
              if (!under) begin
                state <= S_CLR;
              end
            end
            default: begin
              state <= S_DONE;
            end
          endcase
        end
        S_MUL: begin
          count <= cnt_m1;
          state <= S_DONE;
        end
        S_DIV: begin
          if (div_done) begin
            count <= cnt_m1;
            state <= S_DONE;
          end
        end
        S_CLR: begin
          state <= S_DONE;
        end
        S_DONE: begin
          if (!out_valid || out_ready) begin
            out_valid <= 1'b1;
            state     <= S_IDLE;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

  // Payload registers: command, cached top of stack, status
  always_ff @(posedge clk) begin
    case (state)
      S_IDLE: begin
        func_q    <= func;
        operand_q <= operand;
        status_q  <= ST_OK;
      end
      S_EXEC: begin
        case (func_q)
          FN_PUSH: begin
            if (full) begin
              status_q <= ST_FULL;
            end else begin
              top <= operand_q;
            end
          end
          FN_ADD, FN_SUB: begin
            if (under) begin
              status_q <= ST_UNDER;
            end else begin
              top      <= sum_res;
              status_q <= sum_ovf ? ST_SAT : ST_OK;
            end
          end
          FN_MUL: begin
            if (under) begin
              status_q <= ST_UNDER;
            end
            prod <= left * right;
          end
          FN_DIV: begin
            if (under) begin
              status_q <= ST_UNDER;
            end else if (right == '0) begin
              status_q <= ST_DIVZ;
            end
            div_neg <= left[DATA_W-1] ^ right[DATA_W-1];
          end
          FN_CLR: begin
            if (under) begin
              status_q <= ST_UNDER;
            end else begin
              top <= '0;
            end
          end
          FN_READ: begin
            status_q <= (count == '0) ? ST_UNDER : ST_OK;
          end
          default: begin
            status_q <= ST_OK;
          end
        endcase
      end
      S_MUL: begin
        top      <= mul_res;
        status_q <= mul_ovf ? ST_SAT : ST_OK;
      end
      S_DIV: begin
        if (div_done) begin
          top      <= div_res;
          status_q <= div_ovf ? ST_SAT : ST_OK;
        end
      end
      default: begin
        status_q <= status_q;
      end
    endcase
  end

  // Output register: load the finished transaction
  assign cnt_ext = {{DEPTH_OUT_W{1'b0}}, count};

  always_ff @(posedge clk) begin
    if (state == S_DONE && (!out_valid || out_ready)) begin
      top_value   <= (count == '0) ? data_t'(0) : top;
      stack_depth <= cnt_ext[DEPTH_OUT_W-1:0];
      status      <= status_q;
    end
  end

endmodule
